FILE: hdl/mrrx_pkg.sv
package mrrx_pkg;

  // depth of the queue between the byte classifier and the frame engine
  localparam int unsigned QueueDepth = 2;

  // crc-16/modbus, reflected form
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // kinds of input item
  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;

  // configuration register indexes
  localparam logic CfgSlaveId       = 1'b0;
  localparam logic CfgSilenceReload = 1'b1;

  // function codes with their own request class
  localparam logic [7:0] FnReadCoils    = 8'd1;
  localparam logic [7:0] FnReadHolding  = 8'd3;
  localparam logic [7:0] FnWriteCoil    = 8'd5;
  localparam logic [7:0] FnWriteRegister = 8'd6;

  typedef enum logic [1:0] {
    KindRead  = 2'd0,
    KindWrite = 2'd1,
    KindOther = 2'd2
  } req_kind_e;

  // input item
  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic       tx_busy;
  } req_item_t;

  // result item
  typedef struct packed {
    logic [1:0]  request_kind;
    logic [7:0]  function_code;
    logic [15:0] reg_address;
    logic [15:0] data_word;
  } req_result_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       start_ok;
  } rx_entry_t;

  // valid flag of the queue ports
  typedef struct packed {
    logic valid;
  } hs_t;

  // one byte through the crc, lsb first
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/mrrx_front.sv
module mrrx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mrrx_pkg::req_item_t in_item_i,
  output mrrx_pkg::hs_t       push_o,
  input  logic                push_ready_i,
  output mrrx_pkg::rx_entry_t push_entry_o
);

  logic [7:0] slave_id_q;
  logic [3:0] silence_reload_q;
  logic [3:0] silence_q, silence_d;
  logic       accept;
  logic       is_tick;

  assign is_tick    = (in_item_i.req_type == mrrx_pkg::ReqTick);
  assign accept     = in_valid_i && push_ready_i;
  assign in_ready_o = push_ready_i;

  // bytes go to the queue, ticks stay here
  assign push_o.valid = in_valid_i && !is_tick;
  assign push_entry_o.data = in_item_i.rx_byte;
  assign push_entry_o.start_ok = (silence_q == 4'd0) &&
                                 (in_item_i.rx_byte == slave_id_q) &&
                                 !in_item_i.tx_busy;

  // silence counter: bytes reload, ticks count down to zero
  always_comb begin
    silence_d = silence_q;
    if (accept) begin
      if (is_tick) begin
        if (silence_q != 4'd0) silence_d = silence_q - 4'd1;
      end else begin
        silence_d = silence_reload_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_id_q       <= 8'd1;
      silence_reload_q <= 4'd3;
      silence_q        <= 4'd0;
    end else begin
      silence_q <= silence_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          mrrx_pkg::CfgSlaveId:       slave_id_q       <= cfg_data_i;
          mrrx_pkg::CfgSilenceReload: silence_reload_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/mrrx_queue.sv
module mrrx_queue #(
  parameter int unsigned Depth = mrrx_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  mrrx_pkg::rx_entry_t push_entry_i,
  output mrrx_pkg::hs_t       pop_o,
  input  logic                pop_ready_i,
  output mrrx_pkg::rx_entry_t pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mrrx_pkg::rx_entry_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_o.valid  = (count_q != '0);
  assign pop_entry_o  = entries_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_o.valid && pop_ready_i;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= push_entry_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

FILE: hdl/mrrx_back.sv
module mrrx_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  mrrx_pkg::rx_entry_t   pop_entry_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mrrx_pkg::req_result_t out_item_o
);

  localparam logic [2:0] PosStart = 3'd0;
  localparam logic [2:0] PosCrcLo = 3'd6;
  localparam logic [2:0] PosCrcHi = 3'd7;

  logic [2:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  bytes_q [1:5];
  logic        out_valid_q, out_valid_d;
  mrrx_pkg::req_result_t out_item_q, out_item_d;
  logic        pop;
  logic        emit;
  logic [15:0] crc_next;
  mrrx_pkg::req_kind_e kind;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign crc_next    = mrrx_pkg::crc_add_byte(crc_q, pop_entry_i.data);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // request class from the function code
  always_comb begin
    if (bytes_q[1] == mrrx_pkg::FnReadCoils || bytes_q[1] == mrrx_pkg::FnReadHolding) begin
      kind = mrrx_pkg::KindRead;
    end else if (bytes_q[1] == mrrx_pkg::FnWriteCoil ||
                 bytes_q[1] == mrrx_pkg::FnWriteRegister) begin
      kind = mrrx_pkg::KindWrite;
    end else begin
      kind = mrrx_pkg::KindOther;
    end
  end

  // frame position and crc
  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    emit  = 1'b0;
    if (pop) begin
      case (pos_q)
        PosStart: begin
          if (pop_entry_i.start_ok) begin
            crc_d = crc_next;
            pos_d = 3'd1;
          end
        end
        PosCrcLo: begin
          if (pop_entry_i.data == crc_q[7:0]) begin
            pos_d = PosCrcHi;
          end else begin
            pos_d = PosStart;
            crc_d = mrrx_pkg::CrcInit;
          end
        end
        PosCrcHi: begin
          emit  = (pop_entry_i.data == crc_q[15:8]);
          pos_d = PosStart;
          crc_d = mrrx_pkg::CrcInit;
        end
        default: begin
          crc_d = crc_next;
          pos_d = pos_q + 3'd1;
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (emit) begin
      out_valid_d              = 1'b1;
      out_item_d.request_kind  = kind;
      out_item_d.function_code = bytes_q[1];
      out_item_d.reg_address   = {bytes_q[2], bytes_q[3]};
      out_item_d.data_word     = {bytes_q[4], bytes_q[5]};
    end
  end

  // kept frame bytes and result item
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    if (pop) begin
      case (pos_q)
        3'd1:    bytes_q[1] <= pop_entry_i.data;
        3'd2:    bytes_q[2] <= pop_entry_i.data;
        3'd3:    bytes_q[3] <= pop_entry_i.data;
        3'd4:    bytes_q[4] <= pop_entry_i.data;
        3'd5:    bytes_q[5] <= pop_entry_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosStart;
      crc_q       <= mrrx_pkg::CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/modbus_rtu_request_receiver.sv
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+---------------------------------
// in       | input     | in_valid_i/in_ready_o | in_item_i: req_type, rx_byte, tx_busy
// out      | output    | out_valid_o/out_ready_i | out_item_o: kind, code, addr, data
// cfg      | input     | cfg_we_i, no wait     | cfg_index_i, cfg_data_i
//
// one item per cycle while the queue has room; a frame result reaches the output
// register after its last byte has passed the queue and the frame engine
// the silence counter and the start check sit in the front, the crc in the back
// reset clears position, crc, silence counter and queue; no clearing pass
// a full queue drops in_ready_o; a stalled result backs up the frame engine and queue
module modbus_rtu_request_receiver #(
  parameter int unsigned QueueDepth = mrrx_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mrrx_pkg::req_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mrrx_pkg::req_result_t out_item_o
);

  mrrx_pkg::hs_t       push_hs;
  mrrx_pkg::hs_t       pop_hs;
  mrrx_pkg::rx_entry_t push_entry;
  mrrx_pkg::rx_entry_t pop_entry;
  logic                push_ready;
  logic                pop_ready;

  // byte classifier and silence timing
  mrrx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_o       (push_hs),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // queue between classifier and frame engine
  mrrx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_hs.valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_o        (pop_hs),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // frame assembly, crc check and result register
  mrrx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_hs.valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: verif/tb_modbus_rtu_request_receiver.sv
`timescale 1ns / 100ps

module tb_modbus_rtu_request_receiver;

  // ways of spoiling the crc of a generated request
  localparam int CrcGood    = 0;
  localparam int CrcBadLow  = 1;
  localparam int CrcBadHigh = 2;

  localparam int MaxGap = 16;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_index_i;
  logic [7:0]            cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  mrrx_pkg::req_item_t   in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  mrrx_pkg::req_result_t out_item_o;

  // receiver model state, updated at each accepted item
  logic [7:0]  own_id       = 8'd1;
  logic [3:0]  quiet_reload = 4'd3;
  logic [3:0]  quiet_left   = 4'd0;
  logic [2:0]  frame_pos    = 3'd0;
  logic [7:0]  kept [6];
  logic [15:0] run_crc      = mrrx_pkg::CrcInit;

  mrrx_pkg::req_result_t pending_results [$];
  mrrx_pkg::req_result_t want;
  int          mismatches = 0;
  int          items_sent = 0;
  bit          no_idle    = 1'b0;

  // generator's copy of the register values
  logic [7:0]  cur_id     = 8'd1;
  logic [3:0]  cur_reload = 4'd3;

  modbus_rtu_request_receiver DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // crc-16/modbus, one data bit at a time
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[3'(i)]) r = {1'b0, r[15:1]} ^ mrrx_pkg::CrcPoly;
      else r = {1'b0, r[15:1]};
    end
    return r;
  endfunction

  // advance the receiver model by one item, queue any decoded request
  task automatic predict_request(input mrrx_pkg::req_item_t it);
    mrrx_pkg::req_result_t res;
    mrrx_pkg::req_kind_e   kind;
    if (it.req_type == mrrx_pkg::ReqTick) begin
      if (quiet_left != 4'd0) quiet_left = quiet_left - 4'd1;
    end else begin
      case (frame_pos)
        3'd0: begin
          if (quiet_left == 4'd0 && it.rx_byte == own_id && !it.tx_busy) begin
            kept[0]   = it.rx_byte;
            run_crc   = crc16_next(run_crc, it.rx_byte);
            frame_pos = 3'd1;
          end
        end
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5: begin
          kept[frame_pos] = it.rx_byte;
          run_crc         = crc16_next(run_crc, it.rx_byte);
          frame_pos       = frame_pos + 3'd1;
        end
        3'd6: begin
          if (it.rx_byte == run_crc[7:0]) begin
            frame_pos = 3'd7;
          end else begin
            frame_pos = 3'd0;
            run_crc   = mrrx_pkg::CrcInit;
          end
        end
        default: begin
          if (it.rx_byte == run_crc[15:8]) begin
            case (kept[1])
              mrrx_pkg::FnReadCoils, mrrx_pkg::FnReadHolding:
                kind = mrrx_pkg::KindRead;
              mrrx_pkg::FnWriteCoil, mrrx_pkg::FnWriteRegister:
                kind = mrrx_pkg::KindWrite;
              default:
                kind = mrrx_pkg::KindOther;
            endcase
            res.request_kind  = kind;
            res.function_code = kept[1];
            res.reg_address   = {kept[2], kept[3]};
            res.data_word     = {kept[4], kept[5]};
            pending_results.push_back(res);
          end
          frame_pos = 3'd0;
          run_crc   = mrrx_pkg::CrcInit;
        end
      endcase
      quiet_left = quiet_reload;
    end
  endtask

  // check results first, then follow register writes and accepted items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d code %h addr %h data %h",
                     out_item_o.request_kind, out_item_o.function_code,
                     out_item_o.reg_address, out_item_o.data_word);
        end else begin
          want = pending_results.pop_front();
          if (out_item_o.request_kind !== want.request_kind ||
              out_item_o.function_code !== want.function_code ||
              out_item_o.reg_address !== want.reg_address ||
              out_item_o.data_word !== want.data_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected kind %0d code %h addr %h data %h,",
                        " got kind %0d code %h addr %h data %h"},
                       want.request_kind, want.function_code, want.reg_address,
                       want.data_word, out_item_o.request_kind,
                       out_item_o.function_code, out_item_o.reg_address,
                       out_item_o.data_word);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          mrrx_pkg::CfgSlaveId:       own_id = cfg_data_i;
          mrrx_pkg::CfgSilenceReload: quiet_reload = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) predict_request(in_item_i);
    end
  end

  // result side stalls a random number of cycles before each item
  initial begin
    int hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, MaxGap);
      repeat (hold) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
    end
  end

  // random gap, then hold the item until it is taken
  task automatic send_item(input mrrx_pkg::req_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic busy);
    mrrx_pkg::req_item_t it;
    it.req_type = mrrx_pkg::ReqByte;
    it.rx_byte  = b;
    it.tx_busy  = busy;
    send_item(it);
  endtask

  // tick items carry random filler in the unused fields
  task automatic send_ticks(input int n);
    mrrx_pkg::req_item_t it;
    repeat (n) begin
      it.req_type = mrrx_pkg::ReqTick;
      it.rx_byte  = 8'($urandom);
      it.tx_busy  = 1'($urandom_range(0, 1));
      send_item(it);
    end
  endtask

  // one 8-byte request, optionally spoiled, cut short or sprinkled with ticks
  task automatic send_request(input logic [7:0] addr, input logic [7:0] code,
                              input logic [15:0] reg_addr, input logic [15:0] data,
                              input int crc_fault, input logic busy_first,
                              input int tick_pct, input int cut);
    logic [7:0]  fb [8];
    logic [15:0] c;
    fb[0] = addr;
    fb[1] = code;
    fb[2] = reg_addr[15:8];
    fb[3] = reg_addr[7:0];
    fb[4] = data[15:8];
    fb[5] = data[7:0];
    c = mrrx_pkg::CrcInit;
    for (int i = 0; i < 6; i++) c = crc16_next(c, fb[3'(i)]);
    fb[6] = c[7:0];
    fb[7] = c[15:8];
    if (crc_fault == CrcBadLow) fb[6] = fb[6] ^ 8'($urandom_range(1, 255));
    if (crc_fault == CrcBadHigh) fb[7] = fb[7] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < cut; i++) begin
      send_byte(fb[3'(i)], (i == 0) ? busy_first : 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < tick_pct) send_ticks(1);
    end
  endtask

  // drop valid and let every expected result drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic apply_config(input logic [7:0] id, input logic [3:0] reload);
    settle();
    write_reg(mrrx_pkg::CfgSlaveId, id);
    write_reg(mrrx_pkg::CfgSilenceReload, {4'd0, reload});
    cur_id     = id;
    cur_reload = reload;
  endtask

  // start byte gating at reset settings, then one read request
  task automatic test_start_conditions();
    send_ticks(1);                // tick while already quiet
    send_byte(8'h01, 1'b1);       // transmitter busy
    send_byte(8'h01, 1'b0);       // line not quiet yet
    send_ticks(3);
    send_byte(8'h02, 1'b0);       // other slave address
    send_ticks(3);
    // ticks between every byte must not break the frame
    send_request(8'h01, mrrx_pkg::FnReadCoils, 16'hFFFF, 16'h0000, CrcGood, 1'b0, 100, 8);
  endtask

  // write and other request classes plus both crc faults, no silence needed
  task automatic test_request_kinds();
    apply_config(8'hFF, 4'd0);
    send_request(8'hFF, mrrx_pkg::FnWriteRegister, 16'h0000, 16'hFFFF, CrcGood, 1'b0, 0, 8);
    send_request(8'hFF, 8'hFF, 16'h1234, 16'hABCD, CrcBadHigh, 1'b0, 0, 8);
    send_request(8'hFF, 8'h00, 16'h8001, 16'h7FFE, CrcGood, 1'b0, 0, 8);
    send_request(8'hFF, mrrx_pkg::FnWriteCoil, 16'h00FF, 16'hFF00, CrcBadLow, 1'b0, 0, 8);
  endtask

  // mostly well-formed requests with random content, the rest noise
  task automatic run_traffic(input int n);
    int                  target;
    int                  pick;
    logic [7:0]          code;
    logic [15:0]         ra;
    logic [15:0]         dw;
    mrrx_pkg::req_item_t it;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 9) == 0) send_ticks($urandom_range(0, cur_reload));
        else send_ticks(cur_reload + $urandom_range(0, 2));
        pick = $urandom_range(0, 4);
        case (pick)
          0: code = mrrx_pkg::FnReadCoils;
          1: code = mrrx_pkg::FnReadHolding;
          2: code = mrrx_pkg::FnWriteCoil;
          3: code = mrrx_pkg::FnWriteRegister;
          default: code = 8'($urandom);
        endcase
        ra = ($urandom_range(0, 9) == 0) ? {16{1'($urandom_range(0, 1))}} : 16'($urandom);
        dw = ($urandom_range(0, 9) == 0) ? {16{1'($urandom_range(0, 1))}} : 16'($urandom);
        pick = $urandom_range(0, 99);
        send_request(($urandom_range(0, 19) == 0) ? 8'($urandom) : cur_id, code, ra, dw,
                     (pick < 80) ? CrcGood : (pick < 90) ? CrcBadLow : CrcBadHigh,
                     ($urandom_range(0, 99) < 8), 8,
                     ($urandom_range(0, 19) == 0) ? $urandom_range(1, 7) : 8);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          it.req_type = 1'($urandom_range(0, 1));
          it.rx_byte  = ($urandom_range(0, 2) == 0) ? cur_id : 8'($urandom);
          it.tx_busy  = 1'($urandom_range(0, 1));
          send_item(it);
        end
      end
    end
  endtask

  // several register settings, extremes first
  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_config(8'h00, 4'd15);
        1: apply_config(8'hFF, 4'd0);
        2: apply_config(8'h01, 4'd1);
        default: apply_config(8'($urandom), 4'($urandom_range(0, 15)));
      endcase
      no_idle = (phase == 3) || ($urandom_range(0, 3) == 0);
      run_traffic(230);
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = mrrx_pkg::CfgSlaveId;
    cfg_data_i  = 8'h00;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_start_conditions();
    test_request_kinds();
    test_random_traffic();

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/mrrx_pkg.sv
hdl/mrrx_front.sv
hdl/mrrx_queue.sv
hdl/mrrx_back.sv
hdl/modbus_rtu_request_receiver.sv
verif/tb_modbus_rtu_request_receiver.sv
